// File: rtl/ppsf_pkg.sv
package ppsf_pkg;

  localparam int DEFAULT_DEPTH = 32;

  localparam int FULL_LEVEL_W = 6;
  localparam int VOLUME_W     = 4;
  localparam int CFG_DATA_W   = 6;
  localparam int CFG_INDEX_W  = 1;
  localparam int SAMPLE_W     = 16;

  typedef logic [7:0]          byte_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_LEVEL = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME     = 1'b1;

  localparam logic [FULL_LEVEL_W-1:0] FULL_LEVEL_RST = 6'd16;
  localparam logic [VOLUME_W-1:0]     VOLUME_RST     = 4'd8;
  localparam logic [VOLUME_W-1:0]     MAX_SHIFT      = 4'd8;
  localparam logic signed [8:0]       CENTER_OFFSET  = 9'sd128;

  // output word flags, highest bit first
  typedef struct packed {
    logic overflow;
    logic fifo_full;
    logic sample_valid;
  } out_flags_t;

  // center the unsigned byte and apply the volume shift, saturated at eight
  function automatic sample_t scale_sample(input byte_t b, input logic [VOLUME_W-1:0] vol);
    logic signed [8:0]  centered;
    logic [VOLUME_W-1:0] sh;
    logic signed [16:0] wide;
    centered = $signed({1'b0, b}) - CENTER_OFFSET;
    sh       = (vol > MAX_SHIFT) ? MAX_SHIFT : vol;
    wide     = {{8{centered[8]}}, centered} <<< sh;
    return wide[SAMPLE_W-1:0];
  endfunction

endpackage

// File: rtl/parallel_port_sound_fifo_core.sv
// Byte FIFO for a parallel-port sound source with a half-rate sample output.
// Input stream (s_*): s_tdata carries the audio byte, s_tuser[0] the kind of
// word: 0 pushes the byte, 1 is an output sample tick.
// Output stream (m_*): one word per input word. m_tdata is the signed sample
// (held sample on a tick, zero on a push); m_tuser carries sample_valid,
// fifo_full and overflow from bit 0 up.
// Config port: cfg_we writes cfg_data into register cfg_index (0 = full level,
// 1 = volume shift); write only while the block is idle.
// On acceptance the pointers are updated and the byte memory is read into its
// registered read port; the registered read data is then scaled and written
// to the output register. The next word is taken only once the block is idle
// again; while a result waits in the output register the next word is still
// taken, and the block holds its own result until the output register frees up.
// Every second tick pops one byte (zero if the store is empty); the other ticks repeat the held sample.
// A push into a completely full store is dropped and flagged as overflow.
// Reset clears pointers, count, flags, held sample and restores the register
// defaults (full level 16, volume shift 8); the memory is not cleared.
module parallel_port_sound_fifo_core #(
  parameter int STORE_DEPTH = ppsf_pkg::DEFAULT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ppsf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ppsf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // data_byte
  input  logic [0:0]                          s_tuser,  // req_type
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ppsf_pkg::SAMPLE_W-1:0]       m_tdata,  // sample
  output logic [2:0]                          m_tuser   // sample_valid, fifo_full, overflow
);
  import ppsf_pkg::*;

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int CMPW = (CW > FULL_LEVEL_W) ? CW : FULL_LEVEL_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]              state;
  logic [AW-1:0]           rd_idx;
  logic [AW-1:0]           wr_idx;
  logic [CW-1:0]           count;
  logic                    phase;
  logic                    full_flag;
  sample_t                 held_sample;
  logic [FULL_LEVEL_W-1:0] full_level;
  logic [VOLUME_W-1:0]     volume;

  logic                    item_tick;
  logic                    item_pop_read;
  logic                    item_pop_empty;
  out_flags_t              item_flags;
  sample_t                 res_sample;

  logic                    accept;
  logic                    is_tick;
  logic                    store_full;
  logic                    have_data;
  logic [CW-1:0]           count_inc;
  logic [CW-1:0]           count_dec;
  logic [CW-1:0]           count_after_pop;
  logic                    do_write;
  logic                    do_read;
  logic                    push_hits_level;
  logic                    pop_below_level;
  logic                    out_free;
  byte_t                   rdata;
  sample_t                 calc_sample;
  logic [AW-1:0]           rd_idx_next;
  logic [AW-1:0]           wr_idx_next;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign is_tick    = s_tuser[0];
  assign store_full = (count == CW'(STORE_DEPTH));
  assign have_data  = (count != '0);
  assign count_inc  = count + CW'(1);
  assign count_dec  = count - CW'(1);
  assign count_after_pop = have_data ? count_dec : count;

  assign do_write = accept && !is_tick && !store_full;
  assign do_read  = accept && is_tick && phase && have_data;

  assign push_hits_level = (CMPW'(count_inc) == CMPW'(full_level));
  assign pop_below_level = (CMPW'(count_after_pop) < CMPW'(full_level));

  assign rd_idx_next = (rd_idx == AW'(STORE_DEPTH - 1)) ? '0 : rd_idx + AW'(1);
  assign wr_idx_next = (wr_idx == AW'(STORE_DEPTH - 1)) ? '0 : wr_idx + AW'(1);

  assign out_free = !m_tvalid || m_tready;

  ppsf_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_write),
    .waddr (wr_idx),
    .wdata (s_tdata),
    .re    (do_read),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  always_comb begin
    if (!item_tick) begin
      calc_sample = '0;
    end else if (item_pop_read) begin
      calc_sample = scale_sample(rdata, volume);
    end else if (item_pop_empty) begin
      calc_sample = '0;
    end else begin
      calc_sample = held_sample;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      full_level <= FULL_LEVEL_RST;
      volume     <= VOLUME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FULL_LEVEL: full_level <= cfg_data;
        REG_VOLUME:     volume     <= cfg_data[VOLUME_W-1:0];
        default: ;
      endcase
    end
  end

  // pointers, count and flags advance at acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      wr_idx    <= '0;
      count     <= '0;
      phase     <= 1'b0;
      full_flag <= 1'b0;
    end else if (accept) begin
      if (!is_tick) begin
        if (!store_full) begin
          wr_idx <= wr_idx_next;
          count  <= count_inc;
          if (push_hits_level) begin
            full_flag <= 1'b1;
          end
        end
      end else begin
        if (phase) begin
          if (have_data) begin
            rd_idx <= rd_idx_next;
            count  <= count_dec;
          end
          if (pop_below_level) begin
            full_flag <= 1'b0;
          end
        end
        phase <= !phase;
      end
    end
  end

  // describe the accepted word for the scaling cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      item_tick      <= is_tick;
      item_pop_read  <= is_tick && phase && have_data;
      item_pop_empty <= is_tick && phase && !have_data;
      item_flags.sample_valid <= is_tick;
      item_flags.overflow     <= !is_tick && store_full;
      if (!is_tick) begin
        item_flags.fifo_full <= full_flag || (!store_full && push_hits_level);
      end else if (phase && pop_below_level) begin
        item_flags.fifo_full <= 1'b0;
      end else begin
        item_flags.fifo_full <= full_flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_sample <= '0;
    end else if (state == ST_CALC && item_tick) begin
      held_sample <= calc_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      res_sample <= calc_sample;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_CALC || state == ST_PUSH) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (out_free) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CALC && out_free) begin
      m_tdata <= calc_sample;
      m_tuser <= item_flags;
    end else if (state == ST_PUSH && out_free) begin
      m_tdata <= res_sample;
      m_tuser <= item_flags;
    end
  end

endmodule

// File: rtl/ppsf_store.sv
module ppsf_store #(
  parameter int DEPTH = ppsf_pkg::DEFAULT_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  ppsf_pkg::byte_t          wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output ppsf_pkg::byte_t          rdata
);
  import ppsf_pkg::*;

  byte_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ppsf_pkg::*;

  localparam int DEPTH         = 32;
  localparam int BYTE_MIDPOINT = 128;
  localparam int VOLUME_CAP    = 8;
  localparam int PHASES        = 8;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_e;

  typedef struct packed {
    sample_t sample;
    logic    sample_valid;
    logic    fifo_full;
    logic    overflow;
  } sound_result_t;

  // Mirror of the FIFO, the tick phase and the two registers; every accepted
  // word yields exactly one expected output word.
  class sound_fifo_scoreboard;
    byte_t               store [DEPTH];
    logic [4:0]          rd_ptr;
    logic [4:0]          wr_ptr;
    logic [5:0]          count;
    logic                pop_phase;
    logic                full;
    sample_t             held;
    logic [5:0]          full_level;
    logic [3:0]          volume;
    sound_result_t       expected_q[$];
    int                  errors;

    function new();
      rd_ptr     = '0;
      wr_ptr     = '0;
      count      = '0;
      pop_phase  = 1'b0;
      full       = 1'b0;
      held       = '0;
      full_level = FULL_LEVEL_RST;
      volume     = VOLUME_RST;
      errors     = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FULL_LEVEL: full_level = val;
        REG_VOLUME:     volume = val[3:0];
        default: ;
      endcase
    endfunction

    function sample_t centered_scaled(byte_t b);
      int v;
      int sh;
      sh = (volume > VOLUME_CAP) ? VOLUME_CAP : volume;
      v  = (int'(b) - BYTE_MIDPOINT) * (1 << sh);
      return v[15:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_word(req_kind_e req, byte_t b);
      sound_result_t r;
      r = '0;
      if (req == REQ_PUSH) begin
        if (count >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          store[wr_ptr] = b;
          wr_ptr++;
          count++;
          if (count == full_level) full = 1'b1;
        end
      end else begin
        if (pop_phase) begin
          if (count > 0) begin
            held = centered_scaled(store[rd_ptr]);
            rd_ptr++;
            count--;
          end else begin
            held = '0;
          end
          if (count < full_level) full = 1'b0;
        end
        pop_phase       = ~pop_phase;
        r.sample        = held;
        r.sample_valid  = 1'b1;
      end
      r.fifo_full = full;
      expected_q.push_back(r);
    endfunction

    function void check_word(sample_t s, out_flags_t f);
      sound_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("output word with nothing expected: sample %h flags %b", s, f));
        return;
      end
      e = expected_q.pop_front();
      if (s !== e.sample)
        report($sformatf("sample %h, expected %h", s, e.sample));
      if (f.sample_valid !== e.sample_valid)
        report($sformatf("sample_valid %b, expected %b", f.sample_valid, e.sample_valid));
      if (f.fifo_full !== e.fifo_full)
        report($sformatf("fifo_full %b, expected %b", f.fifo_full, e.fifo_full));
      if (f.overflow !== e.overflow)
        report($sformatf("overflow %b, expected %b", f.overflow, e.overflow));
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [7:0]               s_tdata;   // data_byte
  logic [0:0]               s_tuser;   // req_type
  logic                     m_tvalid;
  logic                     m_tready;
  logic [SAMPLE_W-1:0]      m_tdata;   // sample
  logic [2:0]               m_tuser;   // sample_valid, fifo_full, overflow

  sound_fifo_scoreboard sb;
  logic calm;
  logic hold_req;

  parallel_port_sound_fifo_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_word(req_kind_e'(s_tuser[0]), s_tdata);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, out_flags_t'(m_tuser));
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        n = gap_len();
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(req_kind_e req, byte_t b);
    int n;
    if (!calm && $urandom_range(0, 99) < 25) begin
      n = gap_len();
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random(int push_pct);
    if ($urandom_range(0, 99) < push_pct) send_word(REQ_PUSH, byte_t'($urandom_range(0, 255)));
    else send_word(REQ_TICK, byte_t'($urandom_range(0, 255)));
  endtask

  // drop valid, let the last accepted word be noted, then hold until every
  // expected word has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_register(idx, val);
    @(posedge clk);
  endtask

  task automatic run_phase(int n_items, int push_pct);
    int done;
    int k;
    int m;
    done = 0;
    while (done < n_items) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 40) begin
        // burst of pushes, then enough ticks to drain it
        k = $urandom_range(1, 36);
        m = 2 * k + $urandom_range(0, 3);
        repeat (k) send_word(REQ_PUSH, byte_t'($urandom_range(0, 255)));
        repeat (m) send_word(REQ_TICK, byte_t'($urandom_range(0, 255)));
        done += k + m;
      end else begin
        k = $urandom_range(1, 12);
        repeat (k) send_random(push_pct);
        done += k;
      end
    end
  endtask

  initial begin
    int lvl [PHASES];
    int vol [PHASES];
    int pct [PHASES];
    lvl = '{1, 32, 0, 63, 33, 8, 20, 31};
    vol = '{0, 4, 15, 9, 1, 7, 'h35, 8};
    pct = '{50, 80, 35, 70, 60, 90, 45, 65};
    sb        = new();
    calm      = 1'b1;
    hold_req  = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset defaults: empty pops, extreme bytes, then pop past empty
    send_word(REQ_TICK, 8'hA5);
    send_word(REQ_TICK, 8'h5A);
    send_word(REQ_PUSH, 8'h00);
    send_word(REQ_PUSH, 8'hFF);
    send_word(REQ_PUSH, 8'h80);
    send_word(REQ_PUSH, 8'h7F);
    send_word(REQ_PUSH, 8'h01);
    send_word(REQ_PUSH, 8'hFE);
    repeat (14) send_word(REQ_TICK, 8'h00);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_FULL_LEVEL, CFG_DATA_W'(lvl[p]));
      write_reg(REG_VOLUME, CFG_DATA_W'(vol[p]));
      if (p == 2) begin
        // long receiver hold-off while pushes keep coming
        calm     = 1'b1;
        hold_req = 1'b1;
        repeat (60) send_word(REQ_PUSH, byte_t'($urandom_range(0, 255)));
        repeat (40) send_word(REQ_TICK, byte_t'($urandom_range(0, 255)));
      end
      run_phase(170, pct[p]);
      drain();
    end

    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
